@@ hw/rtl/quantized_bilinear_blend_top_defines.svh @@
// Assertion helpers shared by the blend datapath modules.
`ifndef QUANTIZED_BILINEAR_BLEND_TOP_DEFINES_SVH
`define QUANTIZED_BILINEAR_BLEND_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define QBB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define QBB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/qbb_pkg.sv @@
`timescale 1ns / 1ps

package qbb_pkg;

    localparam int PIX_W       = 8;
    localparam int MULT_BITS   = 24;
    localparam int SHIFT_W     = 6;
    localparam int OBITS_W     = 4;
    localparam int BLEND_ONE   = 255;
    localparam int BLEND_ROUND = 1 << 15;
    localparam int BLEND_SHIFT = 16;
    localparam int ZP_SCALE    = BLEND_ONE * BLEND_ONE;

    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 5;
    localparam int REG_IDX_W   = 3;

    localparam logic [REG_IDX_W-1:0] REG_IN_ZP   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_OUT_ZP  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MULT    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SHIFT   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_OBITS   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BYPASS  = 3'd5;

    localparam logic [PIX_W-1:0]     RST_IN_ZP   = 8'd0;
    localparam logic [PIX_W-1:0]     RST_OUT_ZP  = 8'd0;
    localparam logic [MULT_BITS-1:0] RST_MULT    = 24'd8388608;
    localparam logic [SHIFT_W-1:0]   RST_SHIFT   = 6'd23;
    localparam logic [OBITS_W-1:0]   RST_OBITS   = 4'd8;

    typedef struct packed {
        logic [PIX_W-1:0]     in_zero_point;
        logic [PIX_W-1:0]     out_zero_point;
        logic [MULT_BITS-1:0] scale_mult;
        logic [SHIFT_W-1:0]   scale_shift;
        logic [OBITS_W-1:0]   out_bits;
        logic                 bypass_blend;
    } qbb_cfg_t;

endpackage

@@ hw/rtl/qbb_in_if.sv @@
`timescale 1ns / 1ps

interface qbb_in_if
    import qbb_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_tl;
    logic [PIX_W-1:0] pixel_tr;
    logic [PIX_W-1:0] pixel_bl;
    logic [PIX_W-1:0] pixel_br;
    logic [PIX_W-1:0] col_frac;
    logic [PIX_W-1:0] row_frac;

    modport source (
        output valid, pixel_tl, pixel_tr, pixel_bl, pixel_br, col_frac, row_frac,
        input  ready
    );

    modport sink (
        input  valid, pixel_tl, pixel_tr, pixel_bl, pixel_br, col_frac, row_frac,
        output ready
    );
endinterface

@@ hw/rtl/qbb_out_if.sv @@
`timescale 1ns / 1ps

interface qbb_out_if
    import qbb_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;

    modport source (
        output valid, pixel_out,
        input  ready
    );

    modport sink (
        input  valid, pixel_out,
        output ready
    );
endinterface

@@ hw/rtl/qbb_cfg.sv @@
`timescale 1ns / 1ps

module qbb_cfg
    import qbb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output qbb_cfg_t              cfg
);

    qbb_cfg_t                cfg_reg;
    qbb_cfg_t                cfg_next;
    logic                    wr_en;
    logic [REG_IDX_W-1:0]    idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[APB_ADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_IN_ZP:  cfg_next.in_zero_point  = pwdata[PIX_W-1:0];
                REG_OUT_ZP: cfg_next.out_zero_point = pwdata[PIX_W-1:0];
                REG_MULT:   cfg_next.scale_mult     = pwdata[MULT_BITS-1:0];
                REG_SHIFT:  cfg_next.scale_shift    = pwdata[SHIFT_W-1:0];
                REG_OBITS:  cfg_next.out_bits       = pwdata[OBITS_W-1:0];
                REG_BYPASS: cfg_next.bypass_blend   = pwdata[0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.in_zero_point  <= RST_IN_ZP;
            cfg_reg.out_zero_point <= RST_OUT_ZP;
            cfg_reg.scale_mult     <= RST_MULT;
            cfg_reg.scale_shift    <= RST_SHIFT;
            cfg_reg.out_bits       <= RST_OBITS;
            cfg_reg.bypass_blend   <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_IN_ZP:  prdata = APB_DATA_W'(cfg_reg.in_zero_point);
            REG_OUT_ZP: prdata = APB_DATA_W'(cfg_reg.out_zero_point);
            REG_MULT:   prdata = APB_DATA_W'(cfg_reg.scale_mult);
            REG_SHIFT:  prdata = APB_DATA_W'(cfg_reg.scale_shift);
            REG_OBITS:  prdata = APB_DATA_W'(cfg_reg.out_bits);
            REG_BYPASS: prdata = APB_DATA_W'(cfg_reg.bypass_blend);
            default:    prdata = '0;
        endcase
    end

endmodule

@@ hw/rtl/qbb_blend.sv @@
`timescale 1ns / 1ps

module qbb_blend
    import qbb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  qbb_cfg_t           cfg,
    input  logic               adv,
    qbb_in_if.sink             pixels,
    output logic               v_valid,
    output logic signed [8:0]  v_val
);
    `include "quantized_bilinear_blend_top_defines.svh"

    localparam int ACC_W = 26;

    logic [2:0] vld_reg;
    logic [2:0] vld_next;

    // stage 1: horizontal blend of both rows
    logic [PIX_W-1:0] w0;
    logic [15:0]      x0_next, x1_next;
    logic [15:0]      x0_reg, x1_reg;
    logic [PIX_W-1:0] h1_s1_reg, tl_s1_reg;

    // stage 2: vertical weighting, zero point term
    logic [PIX_W-1:0] h0;
    logic [23:0]      p0_next, p1_next, zt_next;
    logic [23:0]      p0_reg, p1_reg, zt_reg;
    logic [PIX_W-1:0] tl_s2_reg;

    // stage 3: sum, rounding downshift, bypass select
    logic signed [ACC_W-1:0] acc;
    logic signed [8:0]       v_byp;
    logic signed [8:0]       v_next;
    logic signed [8:0]       v_reg;

    assign pixels.ready = adv;

    always_comb
    begin
        w0      = ~pixels.col_frac;
        x0_next = 16'(w0) * 16'(pixels.pixel_tl) + 16'(pixels.col_frac) * 16'(pixels.pixel_tr);
        x1_next = 16'(w0) * 16'(pixels.pixel_bl) + 16'(pixels.col_frac) * 16'(pixels.pixel_br);

        h0      = ~h1_s1_reg;
        p0_next = 24'(h0) * 24'(x0_reg);
        p1_next = 24'(h1_s1_reg) * 24'(x1_reg);
        zt_next = 24'(cfg.in_zero_point) * 24'(ZP_SCALE);

        acc     = $signed({2'b00, p0_reg}) + $signed({2'b00, p1_reg})
                + $signed(ACC_W'(BLEND_ROUND)) - $signed({2'b00, zt_reg});
        v_byp   = $signed({1'b0, tl_s2_reg}) - $signed({1'b0, cfg.in_zero_point});
        // rounding shift: the blended value always fits in nine signed bits
        v_next  = cfg.bypass_blend ? v_byp : acc[BLEND_SHIFT+8:BLEND_SHIFT];

        vld_next = {vld_reg[1:0], pixels.valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x0_reg    <= x0_next;
            x1_reg    <= x1_next;
            h1_s1_reg <= pixels.row_frac;
            tl_s1_reg <= pixels.pixel_tl;
            p0_reg    <= p0_next;
            p1_reg    <= p1_next;
            zt_reg    <= zt_next;
            tl_s2_reg <= tl_s1_reg;
            v_reg     <= v_next;
        end
    end

    assign v_valid = vld_reg[2];
    assign v_val   = v_reg;

    `QBB_ASSERT_NXT(a_blend_hold, clk, rst_n, !adv, $stable(vld_reg),
        "blend stage valid changed during a stall")
    `QBB_ASSERT_NXT(a_blend_shift, clk, rst_n, adv,
        vld_reg == {$past(vld_reg[1:0]), $past(pixels.valid)},
        "blend stage valid did not advance with the pipeline")

endmodule

@@ hw/rtl/qbb_requant.sv @@
`timescale 1ns / 1ps

module qbb_requant
    import qbb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  qbb_cfg_t           cfg,
    input  logic               v_valid,
    input  logic signed [8:0]  v_val,
    output logic               adv,
    qbb_out_if.source          result
);
    `include "quantized_bilinear_blend_top_defines.svh"

    localparam int PROD_W    = MULT_BITS + 1 + 9;
    localparam int RND_W     = PROD_W + 2;
    localparam int TOT_W     = PROD_W + 1;
    // beyond this shift the rounded product is always zero
    localparam logic [SHIFT_W-1:0] SHIFT_CAP = SHIFT_W'(PROD_W);

    logic [2:0] vld_reg;
    logic [2:0] vld_next;

    logic signed [PROD_W-1:0] prod_next, prod_reg;

    logic [SHIFT_W-1:0]       sh;
    logic signed [RND_W-1:0]  half;
    logic signed [RND_W-1:0]  sum;
    logic signed [RND_W-1:0]  rnd;
    logic signed [PROD_W-1:0] rs_next, rs_reg;

    logic signed [TOT_W-1:0]  tot;
    logic [OBITS_W-1:0]       nbits;
    logic [PIX_W-1:0]         lim_next, lim_reg;
    logic [PIX_W-1:0]         pix_next, pix_reg;

    assign adv = !vld_reg[2] || result.ready;

    always_comb
    begin
        prod_next = PROD_W'($signed({1'b0, cfg.scale_mult})) * PROD_W'(v_val);

        sh   = (cfg.scale_shift > SHIFT_CAP) ? SHIFT_CAP : cfg.scale_shift;
        half = (sh == '0) ? '0 : (RND_W'(1) <<< (sh - SHIFT_W'(1)));
        sum  = {{(RND_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg} + half;
        rnd  = sum >>> sh;
        rs_next = rnd[PROD_W-1:0];

        tot      = {rs_reg[PROD_W-1], rs_reg} + $signed(TOT_W'(cfg.out_zero_point));
        nbits    = (cfg.out_bits > OBITS_W'(PIX_W)) ? OBITS_W'(PIX_W) : cfg.out_bits;
        lim_next = PIX_W'((9'd1 << nbits) - 9'd1);
        if (tot < 0)
        begin
            pix_next = '0;
        end
        else if (tot > $signed(TOT_W'(lim_next)))
        begin
            pix_next = lim_next;
        end
        else
        begin
            pix_next = tot[PIX_W-1:0];
        end

        vld_next = {vld_reg[1:0], v_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            rs_reg   <= rs_next;
            pix_reg  <= pix_next;
            lim_reg  <= lim_next;
        end
    end

    assign result.valid     = vld_reg[2];
    assign result.pixel_out = pix_reg;

    `QBB_ASSERT_IMP(a_clamp_range, clk, rst_n, vld_reg[2], pix_reg <= lim_reg,
        "output pixel above clamp limit")
    `QBB_ASSERT_NXT(a_reach_out, clk, rst_n, adv && vld_reg[1], vld_reg[2],
        "rounded beat failed to reach the output register")

endmodule

@@ hw/rtl/quantized_bilinear_blend_top.sv @@
// Requantizing bilinear blend of four uint8 neighbours. One pixel beat is
// accepted per cycle while the pipeline advances. Three register stages
// form the horizontal blend, the vertical weighting and the rounding downshift
// (or the bypass subtraction), three more do the 24-bit scale multiply, the
// rounding shift and the zero-point add with clamp. The whole pipeline holds
// while the output beat is not taken, so sustained rate is one beat a cycle
// under a ready sink. Registers sit on the APB port at byte addresses 4*i and
// must only be written while no beat is in flight.
`timescale 1ns / 1ps

module quantized_bilinear_blend_top
    import qbb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    qbb_in_if.sink                pixels,
    qbb_out_if.source             result
);

    qbb_cfg_t          cfg;
    logic              adv;
    logic              v_valid;
    logic signed [8:0] v_val;

    qbb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    qbb_blend u_blend (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .adv     (adv),
        .pixels  (pixels),
        .v_valid (v_valid),
        .v_val   (v_val)
    );

    qbb_requant u_requant (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .v_valid (v_valid),
        .v_val   (v_val),
        .adv     (adv),
        .result  (result)
    );

endmodule
